### rtl/md5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg: shared types, constants and round helpers
// Initial chaining values, the per-round additive constants, shift amounts
// and message word schedule of the MD5 compression.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0]  PAD_BYTE  = 8'h80;
  localparam logic [5:0]  LEN_START = 6'd56;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_work_t;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Message word used by a round: depends on the round group.
  function automatic logic [3:0] md5_msg_idx(logic [5:0] rnd);
    logic [3:0] r4;
    r4 = rnd[3:0];
    case (rnd[5:4])
      2'd0:    md5_msg_idx = r4;
      2'd1:    md5_msg_idx = 4'((r4 << 2) + r4 + 4'd1);
      2'd2:    md5_msg_idx = 4'((r4 << 1) + r4 + 4'd5);
      default: md5_msg_idx = 4'((r4 << 3) - r4);
    endcase
  endfunction

  function automatic logic [4:0] md5_shift(logic [5:0] rnd);
    case ({rnd[5:4], rnd[1:0]})
      4'd0:    md5_shift = 5'd7;
      4'd1:    md5_shift = 5'd12;
      4'd2:    md5_shift = 5'd17;
      4'd3:    md5_shift = 5'd22;
      4'd4:    md5_shift = 5'd5;
      4'd5:    md5_shift = 5'd9;
      4'd6:    md5_shift = 5'd14;
      4'd7:    md5_shift = 5'd20;
      4'd8:    md5_shift = 5'd4;
      4'd9:    md5_shift = 5'd11;
      4'd10:   md5_shift = 5'd16;
      4'd11:   md5_shift = 5'd23;
      4'd12:   md5_shift = 5'd6;
      4'd13:   md5_shift = 5'd10;
      4'd14:   md5_shift = 5'd15;
      default: md5_shift = 5'd21;
    endcase
  endfunction

  function automatic logic [31:0] md5_rotl(logic [31:0] v, logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

  function automatic logic [31:0] md5_bswap(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

### rtl/md5_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_if: message and digest channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_valid;
  logic       msg_last;

  modport source (output valid, output msg_byte, output byte_valid,
                  output msg_last, input ready);
  modport sink   (input valid, input msg_byte, input byte_valid,
                  input msg_last, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        digest_last;

  modport source (output valid, output digest_word, output word_index,
                  output digest_last, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input digest_last, output ready);
endinterface

### rtl/md5_stream_hasher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher_top: streaming MD5 digest engine
// Byte stream in, four byte-swapped digest words out per message.
// ----------------------------------------------------------------------------
// The block takes one message byte per beat and packs four bytes into each
// word of a 16-word block RAM. The beat that fills a block starts a
// compression (load the working values and issue the first RAM read, then
// 64 rounds at one round per cycle fed by the registered RAM read port, then
// fold the result into the chaining values), during which no beat is taken.
// A beat with msg_last set adds the padding: one to sixteen RAM word writes
// and a compression; when eight bytes or fewer remain in the block, a second
// block of sixteen RAM writes and another compression follow. Four digest
// beats then follow, word A first, digest_last on word D; after the last one
// the chaining values return to the initial constants and the next message
// may start. A beat with byte_valid low and msg_last high ends the message
// with the bytes taken so far; with both low it is taken and ignored.
// ----------------------------------------------------------------------------
module md5_stream_hasher_top (
  input  logic      clk,
  input  logic      rst_n,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);
  import md5_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;  // take byte beats
  localparam logic [2:0] S_PAD0 = 3'd1;  // write the word holding 0x80
  localparam logic [2:0] S_PADF = 3'd2;  // write zero or length words
  localparam logic [2:0] S_CPRE = 3'd3;  // load working values
  localparam logic [2:0] S_CRND = 3'd4;  // 64 rounds
  localparam logic [2:0] S_CADD = 3'd5;  // fold into chaining values
  localparam logic [2:0] S_OUT  = 3'd6;  // four digest beats

  logic [2:0]  state_r,     state_nxt;
  logic [5:0]  pos_r,       pos_nxt;
  logic [63:0] msg_r,       msg_nxt;
  logic [23:0] acc_r,       acc_nxt;
  md5_work_t   chain_r,     chain_nxt;
  md5_work_t   work_r,      work_nxt;
  logic [5:0]  rnd_r,       rnd_nxt;
  logic [3:0]  pw_r,        pw_nxt;
  logic        last_pend_r, last_pend_nxt;
  logic        pad_r,       pad_nxt;
  logic        xtra_r,      xtra_nxt;
  logic [1:0]  oidx_r,      oidx_nxt;

  logic        in_beat;
  logic        out_beat;
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;
  md5_work_t   round_out;
  logic [63:0] bit_len;
  logic [31:0] pad_word;
  logic [31:0] out_word;

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign out_beat = out_ch.valid && out_ch.ready;
  assign bit_len  = {msg_r[60:0], 3'b000};

  // Word that carries the 0x80 marker: bytes taken so far stay below it.
  always_comb begin
    case (pos_r[1:0])
      2'd0:    pad_word = {24'h0, PAD_BYTE};
      2'd1:    pad_word = {16'h0, PAD_BYTE, acc_r[7:0]};
      2'd2:    pad_word = {8'h0, PAD_BYTE, acc_r[15:0]};
      default: pad_word = {PAD_BYTE, acc_r[23:0]};
    endcase
  end

  // Issue the read in the cycle before the round that consumes it.
  assign ram_raddr = (state_r == S_CPRE) ? md5_msg_idx(6'd0) : md5_msg_idx(rnd_r + 6'd1);

  md5_blk_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  md5_round u_round (
    .work_i (work_r),
    .m_word (ram_rdata),
    .rnd    (rnd_r),
    .work_o (round_out)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    msg_nxt       = msg_r;
    acc_nxt       = acc_r;
    chain_nxt     = chain_r;
    work_nxt      = work_r;
    rnd_nxt       = rnd_r;
    pw_nxt        = pw_r;
    last_pend_nxt = last_pend_r;
    pad_nxt       = pad_r;
    xtra_nxt      = xtra_r;
    oidx_nxt      = oidx_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r[5:2];
    ram_wdata     = {in_ch.msg_byte, acc_r};

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (in_ch.byte_valid) begin
            // Pack the byte; flush the word on its fourth byte.
            case (pos_r[1:0])
              2'd0:    acc_nxt[7:0]   = in_ch.msg_byte;
              2'd1:    acc_nxt[15:8]  = in_ch.msg_byte;
              2'd2:    acc_nxt[23:16] = in_ch.msg_byte;
              default: ram_we = 1'b1;
            endcase
            pos_nxt = pos_r + 6'd1;
            msg_nxt = msg_r + 64'd1;
            if (pos_r == 6'd63) begin
              last_pend_nxt = in_ch.msg_last;
              state_nxt     = S_CPRE;
            end else if (in_ch.msg_last) begin
              state_nxt = S_PAD0;
            end
          end else if (in_ch.msg_last) begin
            state_nxt = S_PAD0;
          end
        end
      end

      S_PAD0: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[5:2];
        ram_wdata = pad_word;
        pad_nxt   = 1'b1;
        // Too little room for the length: it goes into a second block.
        xtra_nxt  = (pos_r >= LEN_START);
        if (pos_r[5:2] == 4'd15) begin
          state_nxt = S_CPRE;
        end else begin
          pw_nxt    = pos_r[5:2] + 4'd1;
          state_nxt = S_PADF;
        end
      end

      S_PADF: begin
        ram_we    = 1'b1;
        ram_waddr = pw_r;
        if (!xtra_r && pw_r == 4'd14) begin
          ram_wdata = bit_len[31:0];
        end else if (!xtra_r && pw_r == 4'd15) begin
          ram_wdata = bit_len[63:32];
        end else begin
          ram_wdata = 32'h0;
        end
        if (pw_r == 4'd15) begin
          state_nxt = S_CPRE;
        end else begin
          pw_nxt = pw_r + 4'd1;
        end
      end

      S_CPRE: begin
        work_nxt  = chain_r;
        rnd_nxt   = 6'd0;
        state_nxt = S_CRND;
      end

      S_CRND: begin
        work_nxt = round_out;
        if (rnd_r == 6'd63) begin
          state_nxt = S_CADD;
        end else begin
          rnd_nxt = rnd_r + 6'd1;
        end
      end

      S_CADD: begin
        chain_nxt.a = chain_r.a + work_r.a;
        chain_nxt.b = chain_r.b + work_r.b;
        chain_nxt.c = chain_r.c + work_r.c;
        chain_nxt.d = chain_r.d + work_r.d;
        if (last_pend_r) begin
          last_pend_nxt = 1'b0;
          state_nxt     = S_PAD0;
        end else if (pad_r && xtra_r) begin
          xtra_nxt  = 1'b0;
          pw_nxt    = 4'd0;
          state_nxt = S_PADF;
        end else if (pad_r) begin
          oidx_nxt  = 2'd0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_OUT: begin
        if (out_beat) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            // Digest delivered: restart from the initial chaining values.
            chain_nxt = '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
            pos_nxt   = 6'd0;
            msg_nxt   = 64'd0;
            pad_nxt   = 1'b0;
            xtra_nxt  = 1'b0;
            rnd_nxt   = 6'd0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= 6'd0;
      msg_r       <= 64'd0;
      chain_r     <= '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
      rnd_r       <= 6'd0;
      pw_r        <= 4'd0;
      last_pend_r <= 1'b0;
      pad_r       <= 1'b0;
      xtra_r      <= 1'b0;
      oidx_r      <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      msg_r       <= msg_nxt;
      chain_r     <= chain_nxt;
      rnd_r       <= rnd_nxt;
      pw_r        <= pw_nxt;
      last_pend_r <= last_pend_nxt;
      pad_r       <= pad_nxt;
      xtra_r      <= xtra_nxt;
      oidx_r      <= oidx_nxt;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    work_r <= work_nxt;
  end

  always_comb begin
    case (oidx_r)
      2'd0:    out_word = chain_r.a;
      2'd1:    out_word = chain_r.b;
      2'd2:    out_word = chain_r.c;
      default: out_word = chain_r.d;
    endcase
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.digest_word = md5_bswap(out_word);
  assign out_ch.word_index  = oidx_r;
  assign out_ch.digest_last = (oidx_r == 2'd3);

  // Input and digest sides never open together.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while digest pending");

  // Block RAM holds still while rounds read it.
  a_no_write_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRND) |-> !ram_we)
    else $error("block RAM written during rounds");

  // Rounds always start from round zero.
  a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CPRE) |=> (state_r == S_CRND && rnd_r == 6'd0))
    else $error("compression did not start at round zero");

  // After the final digest beat the block is back to taking bytes.
  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_ch.digest_last) |=> (in_ch.ready && pos_r == 6'd0))
    else $error("no return to idle after digest");

endmodule

### rtl/md5_blk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_blk_ram: block word store
// Sixteen 32-bit words, one write port and one registered read port.
// ----------------------------------------------------------------------------
module md5_blk_ram (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/md5_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_round: one MD5 round step
// Mix the working values with one message word and the round constant.
// ----------------------------------------------------------------------------
module md5_round (
  input  md5_pkg::md5_work_t work_i,
  input  logic [31:0]        m_word,
  input  logic [5:0]         rnd,
  output md5_pkg::md5_work_t work_o
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      2'd1:    f = (work_i.b & work_i.d) | (work_i.c & ~work_i.d);
      2'd2:    f = work_i.b ^ work_i.c ^ work_i.d;
      default: f = work_i.c ^ (work_i.b | ~work_i.d);
    endcase
  end

  assign sum = f + work_i.a + m_word + MD5_K[rnd];

  always_comb begin
    work_o.a = work_i.d;
    work_o.b = work_i.b + md5_rotl(sum, md5_shift(rnd));
    work_o.c = work_i.b;
    work_o.d = work_i.c;
  end

endmodule

### test/tb_md5_stream_hasher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_md5_stream_hasher_top: message digest check of the streaming MD5 engine
// Feed byte messages of assorted lengths through the valid/ready input
// channel, fold every accepted beat into an independent MD5 computation, and
// compare each digest beat against the oldest pending prediction. Both sides
// stall at random, with a stretch of full throughput and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_md5_stream_hasher_top;

  localparam realtime     CLK_HALF       = 5.0;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned IDLE_PCT       = 37;
  localparam int unsigned NOISE_PCT      = 5;
  localparam int unsigned ITEM_TARGET    = 370;
  localparam int unsigned MIN_MESSAGES   = 16;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned HOLDOFF_AFTER  = 30;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned QUIET_FROM     = 150;
  localparam int unsigned QUIET_TO       = 240;
  localparam int unsigned MAX_REPORTS    = 10;

  // MD5 chaining values at the start of every message
  localparam logic [31:0] START_WORDS [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };
  localparam logic [7:0]  PAD_MARK = 8'h80;
  // first byte slot of the 64-bit length field
  localparam int unsigned LEN_SLOT = 56;

  // additive round constants, floor(abs(sin(i + 1)) * 2^32)
  localparam logic [31:0] ROUND_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // left-rotate amounts, four per round group
  localparam int unsigned ROT_AMT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       ends_msg;
  } msg_beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        is_last;
  } digest_beat_t;

  logic clk;
  logic rst_n;

  md5_in_if  in_ch();
  md5_out_if out_ch();

  md5_stream_hasher_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Running MD5 state of the message in flight
  logic [31:0]  chain_q [4];
  logic [31:0]  block_q [16];
  logic [5:0]   fill_pos;
  logic [63:0]  byte_count;

  msg_beat_t    stim_q [$];
  digest_beat_t pending_digest_q [$];

  int unsigned  beats_taken;
  int unsigned  fail_cnt;
  int unsigned  cycle_cnt;
  int unsigned  holdoff_left;
  bit           holdoff_done;
  bit           in_beat_moved;

  // Hold both sides at full rate inside this window of input beats.
  function automatic bit no_idle();
    return beats_taken >= QUIET_FROM && beats_taken < QUIET_TO;
  endfunction

  function automatic logic [31:0] rol32(logic [31:0] v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic restart_digest();
    int unsigned k;
    for (k = 0; k < 4; k++) chain_q[k] = START_WORDS[k];
    fill_pos   = '0;
    byte_count = '0;
  endtask

  // Write one byte into the block, little-endian within its word. The first
  // byte of a word overwrites the whole word, so stale bytes never survive.
  task automatic place_byte(logic [5:0] pos, logic [7:0] v);
    if (pos[1:0] == 2'd0) begin
      block_q[pos[5:2]] = {24'd0, v};
    end else begin
      block_q[pos[5:2]][pos[1:0] * 8 +: 8] = v;
    end
  endtask

  // 64 rounds over the current block, then fold into the chaining words.
  task automatic compress_block();
    logic [31:0] a, b, c, d, f, nb;
    int unsigned r, grp, w;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (r = 0; r < 64; r++) begin
      grp = r / 16;
      case (grp)
        0: begin
          f = (b & c) | (~b & d);
          w = r % 16;
        end
        1: begin
          f = (b & d) | (c & ~d);
          w = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          w = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          w = (7 * r) % 16;
        end
      endcase
      nb = b + rol32(f + a + block_q[w] + ROUND_ADD[r], ROT_AMT[grp * 4 + r % 4]);
      a  = d;
      d  = c;
      c  = b;
      b  = nb;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
  endtask

  // Fold one accepted input beat into the digest; on a message end, pad,
  // finish and queue the four byte-swapped digest words.
  task automatic fold_msg_beat(msg_beat_t beat);
    logic [63:0]  bit_len;
    logic [31:0]  swapped;
    digest_beat_t dw;
    int unsigned  k;
    if (beat.has_byte) begin
      place_byte(fill_pos, beat.data);
      byte_count++;
      fill_pos++;
      if (fill_pos == 6'd0) compress_block();
    end
    if (beat.ends_msg) begin
      place_byte(fill_pos, PAD_MARK);
      for (k = fill_pos + 1; k < 64; k++) place_byte(k[5:0], 8'h00);
      // no room left for the length: spill into one more block
      if (fill_pos >= LEN_SLOT) begin
        compress_block();
        for (k = 0; k < 16; k++) block_q[k] = '0;
      end
      bit_len     = byte_count << 3;
      block_q[14] = bit_len[31:0];
      block_q[15] = bit_len[63:32];
      compress_block();
      for (k = 0; k < 4; k++) begin
        swapped    = {<<8{chain_q[k]}};
        dw.word    = swapped;
        dw.index   = k[1:0];
        dw.is_last = (k == 3);
        pending_digest_q.push_back(dw);
      end
      restart_digest();
    end
  endtask

  task automatic push_beat(logic [7:0] data, logic has_byte, logic ends_msg);
    msg_beat_t beat;
    beat.data     = data;
    beat.has_byte = has_byte;
    beat.ends_msg = ends_msg;
    stim_q.push_back(beat);
  endtask

  // Queue one message of random bytes with the occasional empty beat mixed
  // in. Close it either on the last byte or with a separate byteless beat.
  task automatic queue_message(int unsigned len, bit bare_end);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < NOISE_PCT) push_beat(8'($urandom), 1'b0, 1'b0);
      push_beat(8'($urandom), 1'b1, !bare_end && (i == len - 1));
    end
    if (bare_end || len == 0) push_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  always #(CLK_HALF) clk = ~clk;

  // Stop a hung run: no correct run comes near this many cycles.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Input driver: advance to the next queued beat once the current one has
  // moved, or hold it while the block stalls. Idle at random otherwise.
  always @(negedge clk) begin : drive_msg
    msg_beat_t beat;
    if (rst_n) begin
      if (!in_ch.valid || in_beat_moved) begin
        in_beat_moved = 1'b0;
        if (stim_q.size() != 0 && (no_idle() || $urandom_range(99) >= IDLE_PCT)) begin
          beat = stim_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.msg_byte   <= beat.data;
          in_ch.byte_valid <= beat.has_byte;
          in_ch.msg_last   <= beat.ends_msg;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Digest receiver: random back-pressure, plus one long hold-off when the
  // first digest after HOLDOFF_AFTER input beats shows up. The sender keeps
  // offering bytes meanwhile, and the block, holding its digest, stalls input.
  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (!holdoff_done && out_ch.valid && beats_taken >= HOLDOFF_AFTER) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle() || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // Monitor: fold every accepted input beat into the prediction and check
  // every digest beat against the oldest pending word.
  always @(posedge clk) begin : watch_beats
    msg_beat_t    taken;
    digest_beat_t seen;
    digest_beat_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        taken.data     = in_ch.msg_byte;
        taken.has_byte = in_ch.byte_valid;
        taken.ends_msg = in_ch.msg_last;
        fold_msg_beat(taken);
        beats_taken++;
        in_beat_moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.word    = out_ch.digest_word;
        seen.index   = out_ch.word_index;
        seen.is_last = out_ch.digest_last;
        if (pending_digest_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("unexpected digest beat: word %h index %0d last %b",
                     seen.word, seen.index, seen.is_last);
        end else begin
          want = pending_digest_q.pop_front();
          if (seen.word !== want.word || seen.index !== want.index ||
              seen.is_last !== want.is_last) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("digest mismatch: got %h/%0d/%b, wanted %h/%0d/%b",
                       seen.word, seen.index, seen.is_last,
                       want.word, want.index, want.is_last);
          end
        end
      end
    end
  end

  initial begin : run_test
    int unsigned msg_cnt;
    int unsigned len;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.msg_byte   = 8'h00;
    in_ch.byte_valid = 1'b0;
    in_ch.msg_last   = 1'b0;
    out_ch.ready     = 1'b0;
    beats_taken      = 0;
    fail_cnt         = 0;
    cycle_cnt        = 0;
    holdoff_left     = 0;
    holdoff_done     = 1'b0;
    in_beat_moved    = 1'b0;
    restart_digest();

    // Directed: an empty beat outside a message, an empty message (with a
    // junk byte field), single-byte messages at both byte extremes, "abc",
    // and a message closed by a byteless beat after an ignored one.
    push_beat(8'h5a, 1'b0, 1'b0);
    push_beat(8'hff, 1'b0, 1'b1);
    push_beat(8'h00, 1'b1, 1'b1);
    push_beat(8'hff, 1'b1, 1'b1);
    push_beat(8'h61, 1'b1, 1'b0);
    push_beat(8'h62, 1'b1, 1'b0);
    push_beat(8'h63, 1'b1, 1'b1);
    push_beat(8'h80, 1'b1, 1'b0);
    push_beat(8'h7f, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'h00, 1'b0, 1'b1);

    // Padding boundaries with random content: length still fits, length
    // spills into a second block, and an exactly full block.
    queue_message(55, 1'($urandom_range(1)));
    queue_message(56, 1'($urandom_range(1)));
    queue_message(64, 1'($urandom_range(1)));
    msg_cnt = 3;

    // Random messages: mostly short, some around a block, a few around two.
    // Trim the length near the item budget so the total stays close to it.
    while (stim_q.size() < ITEM_TARGET || msg_cnt < MIN_MESSAGES) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: len = $urandom_range(0, 20);
        5, 6, 7:       len = $urandom_range(50, 70);
        8:             len = $urandom_range(118, 130);
        default:       len = $urandom_range(0, 140);
      endcase
      if (stim_q.size() + len > ITEM_TARGET)
        len = (stim_q.size() < ITEM_TARGET) ? ITEM_TARGET - stim_q.size() : 0;
      queue_message(len, ($urandom_range(3) == 0));
      msg_cnt++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: every beat sent, every digest word seen, then let the block
    // settle and catch any stray output.
    while (stim_q.size() != 0 || in_ch.valid || pending_digest_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && pending_digest_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
